// File: hw/rtl/mef_pkg.sv
// ----------------------------------------------------------------------------
// mef_pkg
// Types, widths and constants shared by the moments ellipse fit block.
// ----------------------------------------------------------------------------
package mef_pkg;

   localparam int MOMENT_BITS = 48;
   localparam int AREA_BITS   = 20;
   localparam int ANGLE_BITS  = 16;
   localparam int RADIUS_BITS = 20;
   localparam int XW          = 52;   // CORDIC x/y datapath
   localparam int ZW          = 34;   // CORDIC angle, degrees Q24
   localparam int SUM_BITS    = 49;
   localparam int TW          = 52;   // radius argument width
   localparam int Q_BITS      = 62;   // quotient bits below saturation
   localparam int ROOT_BITS   = 31;
   localparam int SREM_BITS   = ROOT_BITS + 2;

   localparam logic [31:0] INV_GAIN = 32'd2608131496;
   localparam logic signed [ZW-1:0] DEG180 = 34'sd3019898880;
   localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;

   typedef struct packed {
      logic [AREA_BITS-1:0]          area;
      logic [MOMENT_BITS-1:0]        mu_xx;
      logic [MOMENT_BITS-1:0]        mu_yy;
      logic signed [MOMENT_BITS-1:0] mu_xy;
   } mef_req_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle_deg;
      logic [RADIUS_BITS-1:0]       major_radius;
      logic [RADIUS_BITS-1:0]       minor_radius;
      logic                         zero_area;
   } mef_rsp_type;

   typedef struct packed {
      logic                 zero_vec;
      logic                 zero_area;
      logic [SUM_BITS-1:0]  ssum;
      logic [AREA_BITS-1:0] area;
   } mef_side_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      mef_side_type         side;
   } mef_work_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle_deg;
      logic                         zero_area;
   } mef_tag_type;

   typedef struct packed {
      logic [TW-1:0]        t_major;
      logic [TW-1:0]        t_minor;
      logic                 minor_ok;
      logic [AREA_BITS-1:0] area;
      mef_tag_type          tag;
   } mef_rad_in_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [29:0] atan_q24(input int unsigned idx);
      logic [29:0] v;
      unique case (idx)
         0:  v = 30'd754974720;
         1:  v = 30'd445687602;
         2:  v = 30'd235489088;
         3:  v = 30'd119537938;
         4:  v = 30'd60000934;
         5:  v = 30'd30029717;
         6:  v = 30'd15018523;
         7:  v = 30'd7509720;
         8:  v = 30'd3754917;
         9:  v = 30'd1877466;
         10: v = 30'd938734;
         11: v = 30'd469367;
         12: v = 30'd234684;
         13: v = 30'd117342;
         14: v = 30'd58671;
         15: v = 30'd29335;
         16: v = 30'd14668;
         17: v = 30'd7334;
         18: v = 30'd3667;
         19: v = 30'd1833;
         20: v = 30'd917;
         21: v = 30'd458;
         22: v = 30'd229;
         23: v = 30'd115;
         24: v = 30'd57;
         25: v = 30'd29;
         26: v = 30'd14;
         27: v = 30'd7;
         28: v = 30'd4;
         29: v = 30'd2;
         30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/mef_front.sv
// ----------------------------------------------------------------------------
// mef_front
// Classifies a request: folds the moment vector into the right half plane
// and sets the starting angle for the CORDIC.
// ----------------------------------------------------------------------------
module mef_front (
   input  mef_pkg::mef_req_type  req,
   output mef_pkg::mef_work_type work
);

   logic                               dneg;
   logic                               cneg;
   logic [mef_pkg::MOMENT_BITS-1:0]    mx;
   logic [mef_pkg::MOMENT_BITS-1:0]    my;
   logic signed [mef_pkg::XW-1:0]      y2;

   always_comb begin
      dneg = req.mu_yy > req.mu_xx;
      cneg = req.mu_xy[mef_pkg::MOMENT_BITS-1];
      mx   = dneg ? req.mu_yy - req.mu_xx : req.mu_xx - req.mu_yy;
      my   = cneg ? (~req.mu_xy) + 1'b1 : req.mu_xy;
      y2   = $signed({3'b000, my, 1'b0});

      work.x = $signed({4'b0000, mx});
      work.y = (cneg ^ dneg) ? -y2 : y2;
      if (dneg) begin
         work.z = cneg ? -mef_pkg::DEG180 : mef_pkg::DEG180;
      end else begin
         work.z = '0;
      end
      work.side.zero_vec  = (mx == '0) && (my == '0);
      work.side.zero_area = (req.area == '0);
      work.side.ssum      = mef_pkg::SUM_BITS'(req.mu_xx) + mef_pkg::SUM_BITS'(req.mu_yy);
      work.side.area      = req.area;
   end

endmodule

// File: hw/rtl/mef_queue.sv
// ----------------------------------------------------------------------------
// mef_queue
// Short FIFO between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module mef_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mef_pkg::mef_work_type din,
   input  logic                  pop,
   output mef_pkg::mef_work_type dout,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mef_pkg::mef_work_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CW'(DEPTH));
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// File: hw/rtl/mef_cordic.sv
// ----------------------------------------------------------------------------
// mef_cordic
// Pipelined vectoring CORDIC, one step per stage, followed by angle rounding,
// gain correction and the two radius arguments.
// ----------------------------------------------------------------------------
module mef_cordic #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mef_pkg::mef_work_type   in_work,
   output logic                    out_valid,
   output mef_pkg::mef_rad_in_type out_data
);

   localparam int XW = mef_pkg::XW;
   localparam int ZW = mef_pkg::ZW;
   localparam logic signed [ZW:0] RND = (ZW + 1)'(1) <<< (24 - FRAC_BITS);
   localparam logic signed [ZW:0] LIM = (ZW + 1)'(90) <<< FRAC_BITS;

   logic signed [XW-1:0]  x_ff [0:CORDIC_STEPS];
   logic signed [XW-1:0]  y_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0]  z_ff [0:CORDIC_STEPS];
   mef_pkg::mef_side_type side_ff [0:CORDIC_STEPS];
   logic                  v_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= in_work.x;
         y_ff[0]    <= in_work.y;
         z_ff[0]    <= in_work.z;
         side_ff[0] <= in_work.side;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [ZW-1:0] da;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign da = $signed(ZW'(mef_pkg::atan_q24(i)));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i][XW-1]) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + da;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - da;
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // angle rounding and gain-correction products
   logic signed [ZW:0]                  zr;
   logic signed [ZW:0]                  az;
   logic signed [ZW:0]                  ac;
   logic [XW-1:0]                       xu;
   logic signed [mef_pkg::ANGLE_BITS-1:0] ang_in, ang_ff;
   logic [51:0]                         phi_in, phi_ff;
   logic [63:0]                         plo_in, plo_ff;
   mef_pkg::mef_side_type               sa_ff;
   logic                                va_ff;

   always_comb begin
      zr = $signed({z_ff[CORDIC_STEPS][ZW-1], z_ff[CORDIC_STEPS]}) + RND;
      az = zr >>> (25 - FRAC_BITS);
      priority if (az > LIM) begin
         ac = LIM;
      end else if (az < -LIM) begin
         ac = -LIM;
      end else begin
         ac = az;
      end
      ang_in = side_ff[CORDIC_STEPS].zero_vec ? '0 : ac[mef_pkg::ANGLE_BITS-1:0];
      xu     = x_ff[CORDIC_STEPS][XW-1] ? '0 : x_ff[CORDIC_STEPS];
      phi_in = 52'(xu[XW-1:32]) * 52'(mef_pkg::INV_GAIN);
      plo_in = 64'(xu[31:0]) * 64'(mef_pkg::INV_GAIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
         phi_ff <= phi_in;
         plo_ff <= plo_in;
         sa_ff  <= side_ff[CORDIC_STEPS];
      end
   end

   // magnitude and radius arguments
   logic [mef_pkg::TW-1:0]  rmag;
   logic [mef_pkg::TW-1:0]  sext;
   mef_pkg::mef_rad_in_type rad_in, rad_ff;
   logic                    vb_ff;

   always_comb begin
      rmag                  = phi_ff + 52'(plo_ff[63:32]);
      sext                  = mef_pkg::TW'(sa_ff.ssum);
      rad_in.t_major        = sext + rmag;
      rad_in.t_minor        = sext - rmag;
      rad_in.minor_ok       = sext > rmag;
      rad_in.area           = sa_ff.area;
      rad_in.tag.angle_deg  = ang_ff;
      rad_in.tag.zero_area  = sa_ff.zero_area;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = rad_ff;

endmodule

// File: hw/rtl/mef_radius.sv
// ----------------------------------------------------------------------------
// mef_radius
// Two lanes (major, minor): scaled division by the area, one quotient bit per
// stage, then integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module mef_radius #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mef_pkg::mef_rad_in_type in_data,
   output logic                    out_valid,
   output mef_pkg::mef_rsp_type    out_data
);

   localparam int AB  = mef_pkg::AREA_BITS;
   localparam int QB  = mef_pkg::Q_BITS;
   localparam int RB  = mef_pkg::ROOT_BITS;
   localparam int SRB = mef_pkg::SREM_BITS;
   localparam int K   = 2 * FRAC_BITS + 1;
   localparam int NW  = mef_pkg::TW + K;
   localparam int CW  = (NW > AB + QB) ? NW : AB + QB;
   localparam int DS  = QB;
   localparam int SS  = RB;
   localparam int P   = DS + SS;

   // sideband, stage 0 .. P: valid, area and tag shared, ok and sat flags per lane
   logic                 v_ff    [0:P];
   logic [AB-1:0]        area_ff [0:P];
   mef_pkg::mef_tag_type tag_ff  [0:P];
   logic                 ok_ff   [2][0:P];
   logic                 sat_ff  [2][0:P];

   // division stages 0 .. DS: remainder and numerator/quotient shift register
   logic [AB-1:0]        drem_ff [2][0:DS];
   logic [QB-1:0]        dsr_ff  [2][0:DS];

   // root stages 1 .. SS
   logic [QB-1:0]        sq_ff    [2][1:SS];
   logic [RB-1:0]        sroot_ff [2][1:SS];
   logic [SRB-1:0]       srem_ff  [2][1:SS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff[0] <= in_data.area;
         tag_ff[0]  <= in_data.tag;
      end
   end

   for (genvar p = 1; p <= P; p++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[p] <= 1'b0;
         end else if (en) begin
            v_ff[p] <= v_ff[p-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            area_ff[p] <= area_ff[p-1];
            tag_ff[p]  <= tag_ff[p-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [mef_pkg::TW-1:0] t;
      logic [CW-1:0]          n_ext;
      logic [CW-1:0]          lim;

      assign t     = (l == 0) ? in_data.t_major : in_data.t_minor;
      assign n_ext = CW'(t) << K;
      assign lim   = CW'(in_data.area) << QB;

      always_ff @(posedge clock) begin
         if (en) begin
            ok_ff[l][0]  <= (in_data.area != '0) && ((l == 0) || in_data.minor_ok);
            sat_ff[l][0] <= n_ext >= lim;
            drem_ff[l][0] <= AB'(n_ext >> QB);
            dsr_ff[l][0]  <= n_ext[QB-1:0];
         end
      end

      for (genvar p = 1; p <= P; p++) begin : g_flag
         always_ff @(posedge clock) begin
            if (en) begin
               ok_ff[l][p]  <= ok_ff[l][p-1];
               sat_ff[l][p] <= sat_ff[l][p-1];
            end
         end
      end

      for (genvar j = 1; j <= DS; j++) begin : g_div
         logic [AB:0] r2;
         logic        ge;

         assign r2 = {drem_ff[l][j-1], dsr_ff[l][j-1][QB-1]};
         assign ge = r2 >= {1'b0, area_ff[j-1]};

         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[l][j] <= ge ? AB'(r2 - {1'b0, area_ff[j-1]}) : AB'(r2);
               dsr_ff[l][j]  <= {dsr_ff[l][j-1][QB-2:0], ge};
            end
         end
      end

      for (genvar j = 1; j <= SS; j++) begin : g_sqrt
         logic [QB-1:0]  src_q;
         logic [RB-1:0]  src_root;
         logic [SRB-1:0] src_rem;
         logic [SRB+1:0] rem_n;
         logic [SRB+1:0] trial;
         logic           ge;

         if (j == 1) begin : g_first
            assign src_q    = dsr_ff[l][DS];
            assign src_root = '0;
            assign src_rem  = '0;
         end else begin : g_next
            assign src_q    = sq_ff[l][j-1];
            assign src_root = sroot_ff[l][j-1];
            assign src_rem  = srem_ff[l][j-1];
         end

         assign rem_n = {src_rem, src_q[QB-1:QB-2]};
         assign trial = (SRB + 2)'({src_root, 2'b01});
         assign ge    = rem_n >= trial;

         always_ff @(posedge clock) begin
            if (en) begin
               sq_ff[l][j]    <= {src_q[QB-3:0], 2'b00};
               sroot_ff[l][j] <= {src_root[RB-2:0], ge};
               srem_ff[l][j]  <= ge ? SRB'(rem_n - trial) : SRB'(rem_n);
            end
         end
      end
   end

   logic [mef_pkg::RADIUS_BITS-1:0] rad [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         priority if (!ok_ff[l][P]) begin
            rad[l] = '0;
         end else if (sat_ff[l][P]) begin
            rad[l] = mef_pkg::RADIUS_MAX;
         end else if (sroot_ff[l][SS] > RB'(mef_pkg::RADIUS_MAX)) begin
            rad[l] = mef_pkg::RADIUS_MAX;
         end else begin
            rad[l] = sroot_ff[l][SS][mef_pkg::RADIUS_BITS-1:0];
         end
      end
      out_data.angle_deg    = tag_ff[P].angle_deg;
      out_data.zero_area    = tag_ff[P].zero_area;
      out_data.major_radius = rad[0];
      out_data.minor_radius = rad[1];
   end

   assign out_valid = v_ff[P];

endmodule

// File: hw/rtl/moments_ellipse_fit.sv
// ----------------------------------------------------------------------------
// moments_ellipse_fit
// Ellipse orientation and radii from a blob's area and central moments.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, sustained, while rsp_stall stays low.
// A request passes through the queue, the CORDIC steps, 62 division stages and
//   31 square root stages before it reaches the output register.
// A stall on the response side freezes the pipeline; the queue keeps taking
//   requests until it is full. Synchronous reset empties queue and pipeline.
module moments_ellipse_fit #(
   parameter int FRAC_BITS    = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mef_pkg::mef_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mef_pkg::mef_rsp_type rsp_data
);

   mef_pkg::mef_work_type   work;
   mef_pkg::mef_work_type   q_out;
   mef_pkg::mef_rad_in_type rad_in;
   mef_pkg::mef_rsp_type    rad_out;
   logic                    q_empty;
   logic                    q_full;
   logic                    en;
   logic                    cor_valid;
   logic                    rad_valid;
   logic                    rsp_valid_ff, rsp_valid_in;
   mef_pkg::mef_rsp_type    rsp_data_ff;

   // back end moves whenever the output register can take a new value
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = q_full;

   mef_front u_front (
      .req  (req_data),
      .work (work)
   );

   mef_queue #(
      .DEPTH (4)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_valid && !q_full),
      .din   (work),
      .pop   (en && !q_empty),
      .dout  (q_out),
      .empty (q_empty),
      .full  (q_full)
   );

   mef_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (!q_empty),
      .in_work   (q_out),
      .out_valid (cor_valid),
      .out_data  (rad_in)
   );

   mef_radius #(
      .FRAC_BITS (FRAC_BITS)
   ) u_radius (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cor_valid),
      .in_data   (rad_in),
      .out_valid (rad_valid),
      .out_data  (rad_out)
   );

   assign rsp_valid_in = en ? rad_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rad_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/moments_ellipse_fit_checker.sv
// ----------------------------------------------------------------------------
// moments_ellipse_fit_checker
// Watches the request and response channels, computes the expected ellipse
// orientation and radii for every accepted request, and compares in order.
// ----------------------------------------------------------------------------
module moments_ellipse_fit_checker #(
   parameter int FRAC_BITS    = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  mef_pkg::mef_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mef_pkg::mef_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned RMAX = 64'hFFFFF;
   localparam longint unsigned INV_G = 64'd2608131496;

   mef_pkg::mef_rsp_type fit_queue[$];

   function automatic longint signed floor_shr(longint signed v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned radius_calc(longint unsigned t,
                                                   longint unsigned a, int sh);
      longint unsigned q, rm;
      int k;
      k = 2 * FRAC_BITS + 1 + sh;
      q = t / a;
      rm = t % a;
      for (int i = 0; i < k; i++) begin
         if (q >= (64'd1 << 61)) return RMAX;
         q <<= 1;
         rm <<= 1;
         if (rm >= a) begin
            rm -= a;
            q++;
         end
      end
      q = int_sqrt(q);
      return (q > RMAX) ? RMAX : q;
   endfunction

   function automatic mef_pkg::mef_rsp_type fit_ellipse(mef_pkg::mef_req_type r);
      mef_pkg::mef_rsp_type o;
      longint unsigned area, mxx, myy, rxy, mx, my, xu, rmag, ssum;
      longint signed x, y, z, xs, ys, ang, lim;
      logic dneg, cneg;
      int sh;
      area = 64'(r.area);
      mxx = 64'(r.mu_xx);
      myy = 64'(r.mu_yy);
      rxy = 64'(unsigned'(r.mu_xy));
      dneg = myy > mxx;
      cneg = rxy[mef_pkg::MOMENT_BITS-1];
      mx = dneg ? myy - mxx : mxx - myy;
      my = cneg ? ((~rxy) + 1) & ((64'd1 << mef_pkg::MOMENT_BITS) - 1) : rxy;
      sh = 0;
      while (mx >= (64'd1 << 50) || my >= (64'd1 << 49)) begin
         mx >>= 1;
         my >>= 1;
         sh++;
      end
      x = dneg ? -longint'(mx) : longint'(mx);
      y = longint'(my << 1);
      if (cneg) y = -y;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? (64'sd180 <<< 24) : -(64'sd180 <<< 24);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = floor_shr(x, i & 31);
         ys = floor_shr(y, i & 31);
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += longint'(mef_pkg::atan_q24(i & 31));
         end else begin
            x -= ys;
            y += xs;
            z -= longint'(mef_pkg::atan_q24(i & 31));
         end
      end
      lim = 64'sd90 <<< FRAC_BITS;
      if (mx == 0 && my == 0) begin
         ang = 0;
      end else begin
         ang = floor_shr(z + (64'sd1 <<< (24 - FRAC_BITS)), 25 - FRAC_BITS);
         if (ang > lim) ang = lim;
         if (ang < -lim) ang = -lim;
      end
      xu = (x > 0) ? longint'(x) : 0;
      rmag = (xu >> 32) * INV_G + (((xu & 64'hFFFFFFFF) * INV_G) >> 32);
      ssum = (mxx >> sh) + (myy >> sh);
      o.angle_deg = ang[15:0];
      o.major_radius = '0;
      o.minor_radius = '0;
      o.zero_area = (area == 0);
      if (area != 0) begin
         o.major_radius = 20'(radius_calc(ssum + rmag, area, sh));
         if (ssum > rmag) o.minor_radius = 20'(radius_calc(ssum - rmag, area, sh));
      end
      return o;
   endfunction

   always @(posedge clock) begin
      mef_pkg::mef_rsp_type want;
      if (reset) begin
         fit_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (req_valid && !req_stall)
            fit_queue.insert(fit_queue.size(), fit_ellipse(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (fit_queue.size() == 0) begin
               $display("%0t: response with no request waiting: %p", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = fit_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= fit_queue.size();
      end
   end

endmodule

// File: tb/moments_ellipse_fit_tb.sv
// ----------------------------------------------------------------------------
// moments_ellipse_fit_tb
// Drives directed corner-case moment sets and random blobs with random
// gaps and stalls; a checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module moments_ellipse_fit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 16 + 98;
   localparam int WATCHDOG = 4000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   mef_pkg::mef_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   mef_pkg::mef_rsp_type rsp_data;
   int                   fail_count;
   int                   pending;
   int                   idle_cycles = 0;
   int                   cyc = 0;
   logic                 quiet;
   logic                 running = 0;
   mef_pkg::mef_req_type blob_list[$];

   always #5 clock = ~clock;

   moments_ellipse_fit dut (.*);

   moments_ellipse_fit_checker chk (.*);

   // long stretch with no idling in the middle
   assign quiet = (cyc > 600 && cyc < 1100);

   always @(posedge clock) begin
      cyc <= cyc + 1;
      rsp_stall <= !quiet && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if (!running || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic mef_pkg::mef_req_type random_blob();
      mef_pkg::mef_req_type b;
      int mode;
      mode = $urandom_range(9);
      b.area = {$urandom, $urandom} >> (12 + $urandom_range(31));
      b.mu_xx = {$urandom, $urandom} >> (16 + $urandom_range(47));
      b.mu_yy = {$urandom, $urandom} >> (16 + $urandom_range(47));
      b.mu_xy = {$urandom, $urandom} >> (16 + $urandom_range(47));
      if ($urandom_range(1)) b.mu_xy = -b.mu_xy;
      case (mode)
         0: b.mu_yy = b.mu_xx;
         1: b.mu_xy = 0;
         2: b.area = $urandom_range(3);
         3: {b.mu_xx, b.mu_yy} = {$urandom, $urandom, $urandom};
         default: ;
      endcase
      return b;
   endfunction

   function automatic mef_pkg::mef_req_type blob(logic [19:0] a, logic [47:0] xx,
                                                 logic [47:0] yy, logic [47:0] xy);
      mef_pkg::mef_req_type b;
      b.area = a;
      b.mu_xx = xx;
      b.mu_yy = yy;
      b.mu_xy = xy;
      return b;
   endfunction

   task automatic add_blob(mef_pkg::mef_req_type b);
      blob_list.insert(blob_list.size(), b);
   endtask

   initial begin
      localparam logic [47:0] MMAX = '1;
      logic signed [47:0] xyp, xyn;
      xyp = 48'sh7FFF_FFFF_FFFF;
      xyn = 48'sh8000_0000_0000;
      add_blob(blob(0, 0, 0, 0));
      add_blob(blob(0, 100, 40, 10));
      add_blob(blob(20'hFFFFF, MMAX, MMAX, xyp));
      add_blob(blob(1, MMAX, 0, xyn));
      add_blob(blob(1, 0, MMAX, xyp));
      add_blob(blob(1, MMAX, MMAX, xyn));
      add_blob(blob(50, 500, 500, 0));
      add_blob(blob(50, 400, 100, 0));
      add_blob(blob(50, 100, 400, 0));
      add_blob(blob(50, 100, 400, 150));
      add_blob(blob(50, 100, 400, -48'sd150));
      add_blob(blob(50, 300, 300, 200));
      add_blob(blob(50, 300, 300, -48'sd200));
      add_blob(blob(3, 1, 1, 1000));
      add_blob(blob(1, 0, 0, -48'sd1));
      add_blob(blob(1, 1, 0, 0));
      add_blob(blob(1, 0, 1, 0));
      add_blob(blob(20'hFFFFF, 1, 1, 0));
      add_blob(blob(7, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h5555_5555_5555));
      add_blob(blob(20'h55555, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'hAAAA_AAAA_AAAA));
      for (int i = 0; i < 1600; i++) add_blob(random_blob());

      repeat (8) @(posedge clock);
      reset <= 0;
      running <= 1;
      foreach (blob_list[i]) begin
         while (!quiet && $urandom_range(99) < 7) begin
            req_valid <= 0;
            @(posedge clock);
         end
         req_valid <= 1;
         req_data <= blob_list[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
